/* rtl/hmmd_pkg.sv */
// Shared constants, codes and reset tables for the handheld memory map decoder.
`timescale 1ns / 1ps

package hmmd_pkg;

   localparam int VIDEO_RAM_BYTES = 8192;
   localparam int WORK_RAM_BYTES  = 8192;
   localparam int IO_REG_BYTES    = 128;
   localparam int HIGH_RAM_BYTES  = 128;

   localparam int VRAM_AW  = $clog2(VIDEO_RAM_BYTES);
   localparam int WRAM_AW  = $clog2(WORK_RAM_BYTES);
   localparam int IO_AW    = $clog2(IO_REG_BYTES);
   localparam int HRAM_AW  = $clog2(HIGH_RAM_BYTES);
   localparam int CLR_DEPTH =
      (VIDEO_RAM_BYTES > WORK_RAM_BYTES) ? VIDEO_RAM_BYTES : WORK_RAM_BYTES;
   localparam int CLR_AW   = $clog2(CLR_DEPTH);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [1:0] {
      MODE_READ     = 2'd0,
      MODE_WRITE    = 2'd1,
      MODE_DMA_DONE = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      TGT_INTERNAL   = 3'd0,
      TGT_ROM_READ   = 3'd1,
      TGT_RAM_READ   = 3'd2,
      TGT_BANK_WRITE = 3'd3,
      TGT_RAM_WRITE  = 3'd4,
      TGT_IGNORED    = 3'd5,
      TGT_ERROR      = 3'd6
   } target_type;

   localparam logic [15:0] ADDR_DIV      = 16'hff04;
   localparam logic [15:0] ADDR_TIMER    = 16'hff07;
   localparam logic [15:0] ADDR_SERIAL   = 16'hff01;
   localparam logic [15:0] ADDR_SCANLINE = 16'hff44;
   localparam logic [15:0] ADDR_DMA      = 16'hff46;
   localparam logic [15:0] ADDR_SND_LO   = 16'hff10;
   localparam logic [15:0] ADDR_SND_HI   = 16'hff26;
   localparam logic [7:0]  TIMER_RATE_MASK = 8'h03;

   // Power-up contents of the IO register file.
   function automatic logic [7:0] io_reset_value(input logic [IO_AW-1:0] idx);
      logic [7:0] val;
      case (idx)
         IO_AW'(7'h40): val = 8'h91;
         IO_AW'(7'h44): val = 8'h90;
         IO_AW'(7'h47): val = 8'hfc;
         IO_AW'(7'h48): val = 8'hff;
         IO_AW'(7'h49): val = 8'hff;
         default:       val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

/* rtl/handheld_memory_map_decoder.sv */
// Top level of the handheld memory map decoder: bus access decode over internal memories.
`timescale 1ns / 1ps

// Usage:
// Each item on the req_ channel is one bus access (read, write or DMA-done event).
// Each accepted item produces exactly one item on the rsp_ channel.
// An item is taken in the cycle it is accepted, which also issues the synchronous
// reads of video RAM, work RAM, IO registers and high RAM. The next cycle decodes
// the address, picks the read byte and writes back (the timer control register
// is a read-modify-write). The result lands in the output register at the end
// of that decode cycle; no new item is accepted until the last one has left the
// decode cycle, as the registered memory reads must come ahead of the decode.
// After reset the block runs a clearing pass, writing one entry of each memory
// per cycle until that memory is covered (IO registers get their power-up values);
// req_tready stays low during it. When the receiver stalls, one finished result
// waits in the output register while the next item is accepted and read; that
// item then holds in its decode cycle until the output register frees.
module handheld_memory_map_decoder
   import hmmd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] address, [23:16] write_data
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] read_data, [23:8] cart_address, [31:24] cart_data,
   // [32] timer_rate_changed, [33] serial_valid, [41:34] serial_byte, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [2:0] target
   output logic [2:0]            rsp_tuser
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type           state_ff;
   logic                clear_ff;
   logic [CLR_AW-1:0]   clr_cnt_ff;
   logic                dma_ff, dma_in;
   logic [7:0]          irq_ff, irq_in;

   logic [1:0]          mode_ff;
   logic [15:0]         addr_ff;
   logic [7:0]          wdata_ff;

   logic [7:0]          vram_mem [VIDEO_RAM_BYTES];
   logic [7:0]          wram_mem [WORK_RAM_BYTES];
   logic [7:0]          io_mem   [IO_REG_BYTES];
   logic [7:0]          hram_mem [HIGH_RAM_BYTES];
   logic [7:0]          vram_rd_ff, wram_rd_ff, io_rd_ff, hram_rd_ff;

   logic                rsp_valid_ff;
   logic [7:0]          rd_data_ff, rd_data_in;
   target_type          target_ff, target_in;
   logic [15:0]         cart_addr_ff, cart_addr_in;
   logic [7:0]          cart_data_ff, cart_data_in;
   logic                timer_chg_ff, timer_chg_in;
   logic                ser_valid_ff, ser_valid_in;
   logic [7:0]          ser_byte_ff, ser_byte_in;

   logic                vram_we, wram_we, io_we, hram_we;
   logic [7:0]          io_wdata;
   logic                req_accept, exec_go;
   logic [15:0]         req_addr;

   assign req_addr   = req_tdata[15:0];
   assign req_tready = (state_ff == S_IDLE) && !clear_ff;
   assign req_accept = req_tvalid && req_tready;
   assign exec_go    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   // Decode and write-back of the item held in the request register.
   always_comb begin
      rd_data_in   = 8'h00;
      target_in    = TGT_INTERNAL;
      cart_addr_in = 16'h0000;
      cart_data_in = 8'h00;
      timer_chg_in = 1'b0;
      ser_valid_in = 1'b0;
      ser_byte_in  = 8'h00;
      vram_we      = 1'b0;
      wram_we      = 1'b0;
      io_we        = 1'b0;
      hram_we      = 1'b0;
      io_wdata     = wdata_ff;
      dma_in       = dma_ff;
      irq_in       = irq_ff;
      unique case (mode_type'(mode_ff))
         MODE_READ: begin
            if (addr_ff <= 16'h7fff) begin
               target_in    = TGT_ROM_READ;
               cart_addr_in = addr_ff;
            end else if (addr_ff <= 16'h9fff) begin
               rd_data_in = vram_rd_ff;
            end else if (addr_ff <= 16'hbfff) begin
               target_in    = TGT_RAM_READ;
               cart_addr_in = addr_ff;
            end else if (addr_ff <= 16'hdfff) begin
               rd_data_in = wram_rd_ff;
            end else if (addr_ff <= 16'hfdff) begin
               rd_data_in = dma_ff ? 8'hff : wram_rd_ff;
            end else if (addr_ff <= 16'hfe9f) begin
               target_in = TGT_ERROR;
            end else if (addr_ff <= 16'hfeff) begin
               rd_data_in = 8'h00;
            end else if (addr_ff <= 16'hff7f) begin
               rd_data_in = io_rd_ff;
            end else if (addr_ff <= 16'hfffe) begin
               rd_data_in = hram_rd_ff;
            end else begin
               rd_data_in = irq_ff;
            end
         end
         MODE_WRITE: begin
            if (addr_ff <= 16'h7fff || (addr_ff >= 16'ha000 && addr_ff <= 16'hbfff)) begin
               if (dma_ff) begin
                  target_in = TGT_IGNORED;
               end else begin
                  target_in    = (addr_ff <= 16'h7fff) ? TGT_BANK_WRITE : TGT_RAM_WRITE;
                  cart_addr_in = addr_ff;
                  cart_data_in = wdata_ff;
               end
            end else if (addr_ff <= 16'h9fff) begin
               vram_we = 1'b1;
            end else if (addr_ff <= 16'hdfff) begin
               wram_we = 1'b1;
            end else if (addr_ff <= 16'hfdff) begin
               if (dma_ff) target_in = TGT_IGNORED;
               else wram_we = 1'b1;
            end else if (addr_ff <= 16'hfe9f) begin
               target_in = TGT_ERROR;
            end else if (addr_ff <= 16'hfeff) begin
               target_in = TGT_IGNORED;
            end else if (addr_ff <= 16'hff7f) begin
               if (addr_ff == ADDR_SCANLINE || addr_ff == ADDR_DIV) begin
                  io_we    = 1'b1;
                  io_wdata = 8'h00;
               end else if (addr_ff == ADDR_TIMER) begin
                  // The old value came out of the IO read issued at acceptance.
                  timer_chg_in = ((io_rd_ff ^ wdata_ff) & TIMER_RATE_MASK) != 8'h00;
                  io_we        = 1'b1;
               end else if (addr_ff == ADDR_DMA) begin
                  dma_in = 1'b1;
               end else if (addr_ff >= ADDR_SND_LO && addr_ff <= ADDR_SND_HI) begin
                  target_in = TGT_IGNORED;
               end else if (addr_ff == ADDR_SERIAL) begin
                  io_we        = 1'b1;
                  ser_valid_in = 1'b1;
                  ser_byte_in  = wdata_ff;
               end else begin
                  io_we = 1'b1;
               end
            end else if (addr_ff <= 16'hfffe) begin
               hram_we = 1'b1;
            end else begin
               irq_in = wdata_ff;
            end
         end
         MODE_DMA_DONE: begin
            dma_in = 1'b0;
         end
         default: begin
            target_in = TGT_IGNORED;
         end
      endcase
   end

   // Sequencer, architectural registers and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clear_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
         dma_ff       <= 1'b0;
         irq_ff       <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clear_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_AW'(CLR_DEPTH - 1)) clear_ff <= 1'b0;
         end
         if (rsp_valid_ff && rsp_tready && !exec_go) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  state_ff <= S_EXEC;
                  mode_ff  <= req_tuser;
                  addr_ff  <= req_addr;
                  wdata_ff <= req_tdata[23:16];
               end
            end
            S_EXEC: begin
               if (exec_go) begin
                  state_ff     <= S_IDLE;
                  dma_ff       <= dma_in;
                  irq_ff       <= irq_in;
                  rsp_valid_ff <= 1'b1;
                  rd_data_ff   <= rd_data_in;
                  target_ff    <= target_in;
                  cart_addr_ff <= cart_addr_in;
                  cart_data_ff <= cart_data_in;
                  timer_chg_ff <= timer_chg_in;
                  ser_valid_ff <= ser_valid_in;
                  ser_byte_ff  <= ser_byte_in;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Memories: the clearing pass writes one entry a cycle, items write in the
   // decode cycle, and reads are issued when an item is accepted.
   always_ff @(posedge clock) begin
      if (clear_ff) vram_mem[clr_cnt_ff[VRAM_AW-1:0]] <= 8'h00;
      else if (exec_go && vram_we) vram_mem[addr_ff[VRAM_AW-1:0]] <= wdata_ff;
      if (req_accept) vram_rd_ff <= vram_mem[req_addr[VRAM_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (clear_ff) wram_mem[clr_cnt_ff[WRAM_AW-1:0]] <= 8'h00;
      else if (exec_go && wram_we) wram_mem[addr_ff[WRAM_AW-1:0]] <= wdata_ff;
      if (req_accept) wram_rd_ff <= wram_mem[req_addr[WRAM_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         if ((clr_cnt_ff >> IO_AW) == '0)
            io_mem[clr_cnt_ff[IO_AW-1:0]] <= io_reset_value(clr_cnt_ff[IO_AW-1:0]);
      end else if (exec_go && io_we) begin
         io_mem[addr_ff[IO_AW-1:0]] <= io_wdata;
      end
      if (req_accept) io_rd_ff <= io_mem[req_addr[IO_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         if ((clr_cnt_ff >> HRAM_AW) == '0) hram_mem[clr_cnt_ff[HRAM_AW-1:0]] <= 8'h00;
      end else if (exec_go && hram_we) begin
         hram_mem[addr_ff[HRAM_AW-1:0]] <= wdata_ff;
      end
      if (req_accept) hram_rd_ff <= hram_mem[req_addr[HRAM_AW-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = target_ff;
   assign rsp_tdata  = {6'b0, ser_byte_ff, ser_valid_ff, timer_chg_ff,
                        cart_data_ff, cart_addr_ff, rd_data_ff};

   // An accepted item always moves on to its decode cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_EXEC))
      else $error("accepted item did not enter the decode cycle");

   // No result can appear while the memories are still being cleared.
   assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !rsp_valid_ff)
      else $error("result produced during the clearing pass");

   // The restriction is raised only by a write to the DMA register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(dma_ff) |-> $past(exec_go && mode_ff == MODE_WRITE && addr_ff == ADDR_DMA))
      else $error("access restriction raised without a DMA register write");

   // Cartridge address is zero unless the item goes to the cartridge.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && target_ff != TGT_ROM_READ && target_ff != TGT_RAM_READ &&
       target_ff != TGT_BANK_WRITE && target_ff != TGT_RAM_WRITE) |-> (cart_addr_ff == 16'h0))
      else $error("cartridge address set on a non-cartridge item");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the memory map decoder: directed and random bus accesses against a model.
`timescale 1ns / 1ps

module testbench;
   import hmmd_pkg::*;

   typedef struct {
      mode_type    mode;
      logic [15:0] addr;
      logic [7:0]  data;
   } bus_access_type;

   typedef struct packed {
      logic [7:0]  read_data;
      target_type  target;
      logic [15:0] cart_address;
      logic [7:0]  cart_data;
      logic        rate_changed;
      logic        serial_valid;
      logic [7:0]  serial_byte;
   } bus_result_type;

   localparam int RANDOM_ACCESSES = 650;
   localparam int HOLD_CYCLES     = 120;

   // IO addresses, most with side effects, favored by the random address picker.
   localparam logic [15:0] IO_HOT [8] = '{ADDR_DIV, ADDR_TIMER, ADDR_SERIAL, ADDR_SCANLINE,
                                          ADDR_SND_LO, ADDR_SND_HI, ADDR_TIMER, 16'hff40};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;

   // Shadow copy of the decoder's memories and restriction flag.
   logic [7:0] vram_shadow [VIDEO_RAM_BYTES];
   logic [7:0] wram_shadow [WORK_RAM_BYTES];
   logic [7:0] io_shadow [128];
   logic [7:0] hram_shadow [127];
   logic [7:0] irq_enable_shadow;
   logic       dma_blocked;

   bus_access_type pending_accesses[$];
   bus_result_type expected_results[$];

   int mismatches = 0;
   int accepted_count = 0;
   int checked_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int req_stall_run = 0;
   int longest_req_stall = 0;
   int mode_seen [4] = '{default: 0};
   int target_seen [8] = '{default: 0};

   handheld_memory_map_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic clear_shadow();
      foreach (vram_shadow[i]) vram_shadow[i] = 8'h00;
      foreach (wram_shadow[i]) wram_shadow[i] = 8'h00;
      foreach (io_shadow[i]) io_shadow[i] = 8'h00;
      foreach (hram_shadow[i]) hram_shadow[i] = 8'h00;
      io_shadow[7'h40] = 8'h91;
      io_shadow[7'h44] = 8'h90;
      io_shadow[7'h47] = 8'hfc;
      io_shadow[7'h48] = 8'hff;
      io_shadow[7'h49] = 8'hff;
      irq_enable_shadow = 8'h00;
      dma_blocked = 1'b0;
   endtask

   function automatic bus_result_type decode_access(mode_type mode, logic [15:0] addr,
                                                    logic [7:0] data);
      bus_result_type res;
      logic [6:0]     idx;
      res = '0;
      res.target = TGT_INTERNAL;
      idx = addr[6:0];
      case (mode)
         MODE_READ: begin
            if (addr <= 16'h7fff) begin
               res.target = TGT_ROM_READ;
               res.cart_address = addr;
            end else if (addr <= 16'h9fff) begin
               res.read_data = vram_shadow[addr[12:0]];
            end else if (addr <= 16'hbfff) begin
               res.target = TGT_RAM_READ;
               res.cart_address = addr;
            end else if (addr <= 16'hdfff) begin
               res.read_data = wram_shadow[addr[12:0]];
            end else if (addr <= 16'hfdff) begin
               res.read_data = dma_blocked ? 8'hff : wram_shadow[addr[12:0]];
            end else if (addr <= 16'hfe9f) begin
               res.target = TGT_ERROR;
            end else if (addr <= 16'hfeff) begin
               res.read_data = 8'h00;
            end else if (addr <= 16'hff7f) begin
               res.read_data = io_shadow[idx];
            end else if (addr <= 16'hfffe) begin
               res.read_data = hram_shadow[idx];
            end else begin
               res.read_data = irq_enable_shadow;
            end
         end
         MODE_WRITE: begin
            if (addr <= 16'h7fff || (addr >= 16'ha000 && addr <= 16'hbfff)) begin
               if (dma_blocked) begin
                  res.target = TGT_IGNORED;
               end else begin
                  res.target = (addr <= 16'h7fff) ? TGT_BANK_WRITE : TGT_RAM_WRITE;
                  res.cart_address = addr;
                  res.cart_data = data;
               end
            end else if (addr <= 16'h9fff) begin
               vram_shadow[addr[12:0]] = data;
            end else if (addr <= 16'hdfff) begin
               wram_shadow[addr[12:0]] = data;
            end else if (addr <= 16'hfdff) begin
               if (dma_blocked) res.target = TGT_IGNORED;
               else wram_shadow[addr[12:0]] = data;
            end else if (addr <= 16'hfe9f) begin
               res.target = TGT_ERROR;
            end else if (addr <= 16'hfeff) begin
               res.target = TGT_IGNORED;
            end else if (addr <= 16'hff7f) begin
               if (addr == ADDR_SCANLINE || addr == ADDR_DIV) begin
                  io_shadow[idx] = 8'h00;
               end else if (addr == ADDR_TIMER) begin
                  res.rate_changed = ((io_shadow[idx] ^ data) & TIMER_RATE_MASK) != 8'h00;
                  io_shadow[idx] = data;
               end else if (addr == ADDR_DMA) begin
                  // The DMA register itself keeps its old value.
                  dma_blocked = 1'b1;
               end else if (addr >= ADDR_SND_LO && addr <= ADDR_SND_HI) begin
                  res.target = TGT_IGNORED;
               end else if (addr == ADDR_SERIAL) begin
                  io_shadow[idx] = data;
                  res.serial_valid = 1'b1;
                  res.serial_byte = data;
               end else begin
                  io_shadow[idx] = data;
               end
            end else if (addr <= 16'hfffe) begin
               hram_shadow[idx] = data;
            end else begin
               irq_enable_shadow = data;
            end
         end
         MODE_DMA_DONE: dma_blocked = 1'b0;
         default: res.target = TGT_IGNORED;
      endcase
      return res;
   endfunction

   task automatic add_access(mode_type mode, logic [15:0] addr, logic [7:0] data);
      bus_access_type item;
      item.mode = mode;
      item.addr = addr;
      item.data = data;
      pending_accesses.push_back(item);
   endtask

   // Addresses cluster on a few entries per store so that reads often hit earlier writes.
   function automatic logic [15:0] pick_address();
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0, 1:   return 16'($urandom_range(0, 16'hffff));
         2, 3:   return 16'($urandom_range(0, 16'h7fff));
         4:      return 16'($urandom_range(16'ha000, 16'hbfff));
         5:      return 16'h8000 + 16'($urandom_range(0, 15));
         6:      return 16'h9ff0 + 16'($urandom_range(0, 15));
         7:      return 16'hc000 + 16'($urandom_range(0, 15));
         8:      return 16'hdff0 + 16'($urandom_range(0, 15));
         9, 10:  return 16'he000 + 16'($urandom_range(0, 15));
         11:     return 16'hfe00 + 16'($urandom_range(0, 255));
         12, 13: return IO_HOT[$urandom_range(0, 7)];
         14, 15: return 16'hff00 + 16'($urandom_range(0, 127));
         16:     return 16'hff80 + 16'($urandom_range(0, 126));
         17:     return 16'hffff;
         18:     return IO_HOT[$urandom_range(0, 7)];
         default: return 16'hfdf0 + 16'($urandom_range(0, 15));
      endcase
   endfunction

   function automatic int pick_idle(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t: mismatch in %s on response %0d: got %0h, expected %0h",
               $realtime, what, checked_count, got, want);
      mismatches++;
   endtask

   // Access driver: one access per handshake, with random gaps between them.
   always @(posedge clock) begin : access_driver
      bus_access_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(decode_access(mode_type'(req_tuser), req_tdata[15:0],
                                                     req_tdata[23:16]));
            mode_seen[req_tuser]++;
            accepted_count <= accepted_count + 1;
         end
         if (req_tvalid && !req_tready) begin
            req_stall_run <= req_stall_run + 1;
            if (req_stall_run + 1 > longest_req_stall) longest_req_stall <= req_stall_run + 1;
         end else begin
            req_stall_run <= 0;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
               item = pending_accesses.pop_front();
               req_tdata <= {item.data, item.addr};
               req_tuser <= item.mode;
               req_tvalid <= 1'b1;
               gap_left <= pick_idle(((accepted_count / 80) % 4) == 2 || hold_left > 0);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response ready: random stalls, plus one long hold-off to back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && checked_count >= 250) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_idle(((checked_count / 80) % 4) == 2);
      end
   end

   always @(posedge clock) begin : response_monitor
      bus_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked_count <= checked_count + 1;
         target_seen[rsp_tuser]++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", 16'(rsp_tuser), 16'h0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[7:0] != want.read_data)
               report_mismatch("read_data", 16'(rsp_tdata[7:0]), 16'(want.read_data));
            if (rsp_tuser != want.target)
               report_mismatch("target", 16'(rsp_tuser), 16'(want.target));
            if (rsp_tdata[23:8] != want.cart_address)
               report_mismatch("cart_address", rsp_tdata[23:8], want.cart_address);
            if (rsp_tdata[31:24] != want.cart_data)
               report_mismatch("cart_data", 16'(rsp_tdata[31:24]), 16'(want.cart_data));
            if (rsp_tdata[32] != want.rate_changed)
               report_mismatch("timer_rate_changed", 16'(rsp_tdata[32]),
                               16'(want.rate_changed));
            if (rsp_tdata[33] != want.serial_valid)
               report_mismatch("serial_valid", 16'(rsp_tdata[33]), 16'(want.serial_valid));
            if (rsp_tdata[41:34] != want.serial_byte)
               report_mismatch("serial_byte", 16'(rsp_tdata[41:34]), 16'(want.serial_byte));
            if (rsp_tdata[47:42] != 6'd0)
               report_mismatch("padding", 16'(rsp_tdata[47:42]), 16'h0);
         end
      end
   end

   initial begin : stimulus
      mode_type mode;
      int       r;
      clear_shadow();

      // Directed accesses: region edges, side-effect registers and the DMA restriction.
      add_access(MODE_READ,  16'h0000, 8'h00);
      add_access(MODE_WRITE, 16'hffff, 8'hff);
      add_access(MODE_READ,  16'hffff, 8'h00);
      add_access(MODE_READ,  ADDR_SCANLINE, 8'h00);
      add_access(MODE_WRITE, ADDR_SCANLINE, 8'h55);
      add_access(MODE_READ,  ADDR_SCANLINE, 8'h00);
      add_access(MODE_WRITE, ADDR_DIV, 8'h12);
      add_access(MODE_WRITE, ADDR_TIMER, 8'h03);
      add_access(MODE_WRITE, ADDR_TIMER, 8'h07);
      add_access(MODE_WRITE, ADDR_SERIAL, 8'ha5);
      add_access(MODE_WRITE, ADDR_SND_LO, 8'h11);
      add_access(MODE_WRITE, 16'hc000, 8'h3c);
      add_access(MODE_READ,  16'he000, 8'h00);
      add_access(MODE_WRITE, 16'hfe00, 8'h01);
      add_access(MODE_READ,  16'hfe9f, 8'h00);
      add_access(MODE_READ,  16'hfea0, 8'h00);
      add_access(MODE_WRITE, 16'hfeff, 8'h5a);
      add_access(MODE_WRITE, 16'h7fff, 8'h77);
      add_access(MODE_WRITE, 16'ha000, 8'h88);
      add_access(MODE_WRITE, ADDR_DMA, 8'h00);
      add_access(MODE_WRITE, 16'h2000, 8'h01);
      add_access(MODE_READ,  16'he000, 8'h00);
      add_access(MODE_WRITE, 16'hfdff, 8'hc3);
      add_access(MODE_READ,  16'hbfff, 8'h00);
      add_access(MODE_DMA_DONE, 16'h0000, 8'h00);
      add_access(MODE_UNUSED, 16'hffff, 8'hff);

      for (int n = 0; n < RANDOM_ACCESSES; n++) begin
         r = $urandom_range(0, 99);
         if (r < 45) mode = MODE_READ;
         else if (r < 90) mode = MODE_WRITE;
         else if (r < 95) mode = MODE_DMA_DONE;
         else if (r < 98) mode = MODE_UNUSED;
         else mode = MODE_WRITE;
         if (r >= 98) add_access(mode, ADDR_DMA, 8'($urandom_range(0, 255)));
         else add_access(mode, pick_address(), 8'($urandom_range(0, 255)));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_accesses.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Checked %0d responses: %0d reads, %0d writes, %0d DMA-done, %0d unused mode.",
               checked_count, mode_seen[MODE_READ], mode_seen[MODE_WRITE],
               mode_seen[MODE_DMA_DONE], mode_seen[MODE_UNUSED]);
      $display("Targets: int %0d rom %0d ram %0d bank %0d ramw %0d ign %0d err %0d; %s %0d.",
               target_seen[TGT_INTERNAL], target_seen[TGT_ROM_READ],
               target_seen[TGT_RAM_READ], target_seen[TGT_BANK_WRITE],
               target_seen[TGT_RAM_WRITE], target_seen[TGT_IGNORED], target_seen[TGT_ERROR],
               "longest input stall", longest_req_stall);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Clearing pass plus a few hundred accesses under stalls take well under a millisecond.
   initial begin
      #3_000_000;
      $display("Timed out with %0d responses still expected.", expected_results.size());
      $display("FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/hmmd_pkg.sv
rtl/handheld_memory_map_decoder.sv
test/testbench.sv
